@@ rtl/mrec_pkg.sv @@
// Package for the modular exponentiation cipher unit.
// Holds word width, register indexes, mode codes, command/status types.
package mrec_pkg;
	localparam int WordBits = 32;
	localparam int CntBits = $clog2(WordBits);

	typedef logic [WordBits-1:0] word_t;

	localparam logic [1:0] CfgMode = 2'd0;
	localparam logic [1:0] CfgModulus = 2'd1;
	localparam logic [1:0] CfgExponent = 2'd2;
	localparam logic [1:0] CfgPublicKey = 2'd3;

	localparam logic [1:0] ModeRsa = 2'd0;
	localparam logic [1:0] ModeEncrypt = 2'd1;
	localparam logic [1:0] ModeDecrypt = 2'd2;
	localparam logic [1:0] ModeUnused = 2'd3;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,     // capture inputs, acc = 1, n = modulus
		OP_RED_INIT, // start reduction of base or message (by sel): rem = 0, cnt = top
		OP_RED_STEP, // one restoring division bit
		OP_RED_DONE, // base = rem, or message = rem when sel is SEL_MSG
		OP_MUL_INIT, // start acc * operand, operand chosen by sel; SEL_T0 gives message * t0
		OP_MUL_STEP, // one shift-add bit
		OP_MUL_DONE, // acc = product
		OP_INV_INIT, // r0 = n, r1 = acc, t0 = 0, t1 = 1
		OP_DIV_INIT, // start r0 / r1
		OP_DIV_STEP,
		OP_INV_MUL,  // start q * t1 mod n
		OP_INV_UPD,  // rotate remainders and coefficients
		OP_FINISH    // form result
	} op_t;

	typedef enum logic [1:0] {
		SEL_ACC,
		SEL_BASE,
		SEL_MSG,
		SEL_T0
	} sel_t;

	typedef struct packed {
		op_t op;
		sel_t sel;
		logic zero_res;
		logic flag;
	} cmd_t;

	typedef struct packed {
		logic cnt_last;
		logic r1_zero;
		logic r0_one;
	} sts_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RED_INIT,
		ST_RED,
		ST_RED_DONE,
		ST_EXP_SQ,
		ST_SQ_RUN,
		ST_SQ_DONE,
		ST_EXP_MUL,
		ST_MUL_RUN,
		ST_MUL_DONE,
		ST_INV_INIT,
		ST_INV_TEST,
		ST_DIV,
		ST_INV_MUL,
		ST_INV_MUL_RUN,
		ST_INV_UPD,
		ST_MSG_RED_INIT,
		ST_MSG_RED,
		ST_MSG_RED_DONE,
		ST_FIN_MUL,
		ST_FIN_RUN,
		ST_FIN_DONE,
		ST_FINISH,
		ST_OUT
	} state_t;
endpackage

@@ rtl/mrec_datapath.sv @@
// Datapath: shift-add modular multiplier, restoring divider, Euclid registers.
// Uses mrec_pkg; driven by mrec_ctrl commands.
module mrec_datapath (
	input  logic clk,
	input  mrec_pkg::cmd_t cmd,
	input  mrec_pkg::word_t modulus,
	input  mrec_pkg::word_t exponent,
	input  mrec_pkg::word_t public_key,
	input  logic [1:0] mode,
	input  mrec_pkg::word_t message,
	input  mrec_pkg::word_t ephemeral,
	input  logic exp_sel_tick,
	output mrec_pkg::sts_t sts,
	output logic exp_bit,
	output mrec_pkg::word_t res_word,
	output logic res_flag
);
	localparam int W = mrec_pkg::WordBits;
	localparam int C = mrec_pkg::CntBits;

	mrec_pkg::word_t n_q, e_q, msg_q, base_q, acc_q;
	mrec_pkg::word_t mop_q, mb_q, prod_q;
	mrec_pkg::word_t dnum_q, rem_q, quo_q, dden_q;
	mrec_pkg::word_t r0_q, r1_q, t0_q, t1_q;
	logic [C-1:0] cnt_q, ecnt_q;

	logic [W:0] dbl, dsum, rem_sh, gap;
	mrec_pkg::word_t dbl_r, sum_r, opnd, t2;

	// modular doubling then conditional add (x, y < n)
	always_comb begin
		dbl = {1'b0, prod_q} + {1'b0, prod_q};
		dbl_r = (dbl >= {1'b0, n_q}) ? W'(dbl - {1'b0, n_q}) : dbl[W-1:0];
		dsum = {1'b0, dbl_r} + {1'b0, mop_q};
		sum_r = (dsum >= {1'b0, n_q}) ? W'(dsum - {1'b0, n_q}) : dsum[W-1:0];
		rem_sh = {rem_q, dnum_q[W-1]};
		gap = rem_sh - {1'b0, dden_q};
		t2 = (t0_q >= prod_q) ? (t0_q - prod_q) : W'(t0_q + (n_q - prod_q));
		unique case (cmd.sel)
			mrec_pkg::SEL_ACC:  opnd = acc_q;
			mrec_pkg::SEL_BASE: opnd = base_q;
			mrec_pkg::SEL_MSG:  opnd = msg_q;
			default:            opnd = t0_q;
		endcase
	end

	// advance the datapath on each command
	always_ff @(posedge clk) begin
		case (cmd.op)
			mrec_pkg::OP_LOAD: begin
				n_q <= modulus;
				e_q <= exponent;
				msg_q <= message;
				base_q <= (mode == mrec_pkg::ModeRsa) ? message :
					(mode == mrec_pkg::ModeEncrypt) ? public_key : ephemeral;
				acc_q <= W'(1);
				ecnt_q <= C'(W - 1);
			end
			mrec_pkg::OP_RED_INIT: begin
				dnum_q <= (cmd.sel == mrec_pkg::SEL_MSG) ? msg_q : base_q;
				dden_q <= n_q;
				rem_q <= '0;
				cnt_q <= C'(W - 1);
			end
			mrec_pkg::OP_DIV_INIT: begin
				dnum_q <= r0_q;
				dden_q <= r1_q;
				rem_q <= '0;
				cnt_q <= C'(W - 1);
			end
			mrec_pkg::OP_RED_STEP, mrec_pkg::OP_DIV_STEP: begin
				if (gap[W] == 1'b0) begin
					rem_q <= gap[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b0};
				end
				dnum_q <= {dnum_q[W-2:0], 1'b0};
				cnt_q <= cnt_q - C'(1);
			end
			mrec_pkg::OP_RED_DONE: begin
				if (cmd.sel == mrec_pkg::SEL_MSG)
					msg_q <= rem_q;
				else
					base_q <= rem_q;
			end
			mrec_pkg::OP_MUL_INIT: begin
				// finishing with the inverse multiplies the message by t0
				mop_q <= (cmd.sel == mrec_pkg::SEL_T0) ? msg_q : acc_q;
				mb_q <= opnd;
				prod_q <= '0;
				cnt_q <= C'(W - 1);
			end
			mrec_pkg::OP_INV_MUL: begin
				// q reduced mod n: q < n always holds after the first step; reduce anyway
				mop_q <= t1_q;
				mb_q <= (quo_q >= n_q) ? quo_q - n_q : quo_q;
				prod_q <= '0;
				cnt_q <= C'(W - 1);
			end
			mrec_pkg::OP_MUL_STEP: begin
				prod_q <= mb_q[W-1] ? sum_r : dbl_r;
				mb_q <= {mb_q[W-2:0], 1'b0};
				cnt_q <= cnt_q - C'(1);
			end
			mrec_pkg::OP_MUL_DONE: acc_q <= prod_q;
			mrec_pkg::OP_INV_INIT: begin
				r0_q <= n_q;
				r1_q <= acc_q;
				t0_q <= '0;
				t1_q <= W'(1);
			end
			mrec_pkg::OP_INV_UPD: begin
				r0_q <= r1_q;
				r1_q <= rem_q;
				t0_q <= t1_q;
				t1_q <= t2;
			end
			mrec_pkg::OP_FINISH: begin
				res_word <= cmd.zero_res ? '0 : acc_q;
				res_flag <= cmd.flag;
			end
			default: ;
		endcase
		if (exp_sel_tick)
			ecnt_q <= ecnt_q - C'(1);
	end

	// status back to the controller
	assign sts.cnt_last = (cnt_q == '0);
	assign sts.r1_zero = (r1_q == '0);
	assign sts.r0_one = (r0_q == W'(1));
	assign exp_bit = e_q[ecnt_q];
endmodule

@@ rtl/mrec_ctrl.sv @@
// Controller: sequences reduction, square-and-multiply, inverse and final multiply.
// Uses mrec_pkg; commands mrec_datapath.
module mrec_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  logic [1:0] mode,
	input  mrec_pkg::word_t modulus,
	input  mrec_pkg::sts_t sts,
	input  logic exp_bit,
	output logic exp_sel_tick,
	output mrec_pkg::cmd_t cmd
);
	mrec_pkg::state_t state_q, state_d;
	logic [1:0] mode_q, mode_d;
	logic bad_q, bad_d;
	logic last_bit_q, last_bit_d;
	logic [mrec_pkg::CntBits-1:0] bits_q, bits_d;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrec_pkg::ST_IDLE;
			mode_q <= '0;
			bad_q <= 1'b0;
			last_bit_q <= 1'b0;
			bits_q <= '0;
		end else begin
			state_q <= state_d;
			mode_q <= mode_d;
			bad_q <= bad_d;
			last_bit_q <= last_bit_d;
			bits_q <= bits_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		mode_d = mode_q;
		bad_d = bad_q;
		last_bit_d = last_bit_q;
		bits_d = bits_q;
		cmd = '{op: mrec_pkg::OP_NONE, sel: mrec_pkg::SEL_BASE, zero_res: 1'b0, flag: 1'b0};
		in_ready = 1'b0;
		out_valid = 1'b0;
		exp_sel_tick = 1'b0;
		unique case (state_q)
			mrec_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = mrec_pkg::OP_LOAD;
					mode_d = mode;
					bad_d = (modulus < mrec_pkg::WordBits'(2)) ||
						(mode == mrec_pkg::ModeUnused);
					state_d = mrec_pkg::ST_RED_INIT;
				end
			end
			mrec_pkg::ST_RED_INIT: begin
				cmd.op = mrec_pkg::OP_RED_INIT;
				state_d = bad_q ? mrec_pkg::ST_FINISH : mrec_pkg::ST_RED;
			end
			mrec_pkg::ST_RED: begin
				cmd.op = mrec_pkg::OP_RED_STEP;
				if (sts.cnt_last) state_d = mrec_pkg::ST_RED_DONE;
			end
			mrec_pkg::ST_RED_DONE: begin
				cmd.op = mrec_pkg::OP_RED_DONE;
				bits_d = mrec_pkg::CntBits'(mrec_pkg::WordBits - 1);
				state_d = mrec_pkg::ST_EXP_SQ;
			end
			mrec_pkg::ST_EXP_SQ: begin
				cmd.op = mrec_pkg::OP_MUL_INIT;
				cmd.sel = mrec_pkg::SEL_ACC;
				state_d = mrec_pkg::ST_SQ_RUN;
			end
			mrec_pkg::ST_SQ_RUN: begin
				cmd.op = mrec_pkg::OP_MUL_STEP;
				if (sts.cnt_last) state_d = mrec_pkg::ST_SQ_DONE;
			end
			mrec_pkg::ST_SQ_DONE: begin
				cmd.op = mrec_pkg::OP_MUL_DONE;
				last_bit_d = (bits_q == '0);
				if (exp_bit) state_d = mrec_pkg::ST_EXP_MUL;
				else begin
					exp_sel_tick = 1'b1;
					bits_d = bits_q - 1'b1;
					state_d = (bits_q == '0) ? mrec_pkg::ST_INV_INIT : mrec_pkg::ST_EXP_SQ;
				end
			end
			mrec_pkg::ST_EXP_MUL: begin
				cmd.op = mrec_pkg::OP_MUL_INIT;
				cmd.sel = mrec_pkg::SEL_BASE;
				state_d = mrec_pkg::ST_MUL_RUN;
			end
			mrec_pkg::ST_MUL_RUN: begin
				cmd.op = mrec_pkg::OP_MUL_STEP;
				if (sts.cnt_last) state_d = mrec_pkg::ST_MUL_DONE;
			end
			mrec_pkg::ST_MUL_DONE: begin
				cmd.op = mrec_pkg::OP_MUL_DONE;
				exp_sel_tick = 1'b1;
				bits_d = bits_q - 1'b1;
				state_d = last_bit_q ? mrec_pkg::ST_INV_INIT : mrec_pkg::ST_EXP_SQ;
			end
			mrec_pkg::ST_INV_INIT: begin
				// power done: rsa finishes, encrypt multiplies, decrypt inverts
				if (mode_q == mrec_pkg::ModeRsa) state_d = mrec_pkg::ST_FINISH;
				else if (mode_q == mrec_pkg::ModeEncrypt) state_d = mrec_pkg::ST_MSG_RED_INIT;
				else begin
					cmd.op = mrec_pkg::OP_INV_INIT;
					state_d = mrec_pkg::ST_INV_TEST;
				end
			end
			mrec_pkg::ST_INV_TEST: begin
				if (sts.r1_zero) begin
					if (sts.r0_one) state_d = mrec_pkg::ST_MSG_RED_INIT;
					else begin
						bad_d = 1'b1;
						state_d = mrec_pkg::ST_FINISH;
					end
				end else begin
					cmd.op = mrec_pkg::OP_DIV_INIT;
					state_d = mrec_pkg::ST_DIV;
				end
			end
			mrec_pkg::ST_DIV: begin
				cmd.op = mrec_pkg::OP_DIV_STEP;
				if (sts.cnt_last) state_d = mrec_pkg::ST_INV_MUL;
			end
			mrec_pkg::ST_INV_MUL: begin
				cmd.op = mrec_pkg::OP_INV_MUL;
				state_d = mrec_pkg::ST_INV_MUL_RUN;
			end
			mrec_pkg::ST_INV_MUL_RUN: begin
				cmd.op = mrec_pkg::OP_MUL_STEP;
				if (sts.cnt_last) state_d = mrec_pkg::ST_INV_UPD;
			end
			mrec_pkg::ST_INV_UPD: begin
				cmd.op = mrec_pkg::OP_INV_UPD;
				state_d = mrec_pkg::ST_INV_TEST;
			end
			mrec_pkg::ST_MSG_RED_INIT: begin
				cmd.op = mrec_pkg::OP_RED_INIT;
				cmd.sel = mrec_pkg::SEL_MSG;
				state_d = mrec_pkg::ST_MSG_RED;
			end
			mrec_pkg::ST_MSG_RED: begin
				cmd.op = mrec_pkg::OP_RED_STEP;
				cmd.sel = mrec_pkg::SEL_MSG;
				if (sts.cnt_last) state_d = mrec_pkg::ST_MSG_RED_DONE;
			end
			mrec_pkg::ST_MSG_RED_DONE: begin
				cmd.op = mrec_pkg::OP_RED_DONE;
				cmd.sel = mrec_pkg::SEL_MSG;
				state_d = mrec_pkg::ST_FIN_MUL;
			end
			mrec_pkg::ST_FIN_MUL: begin
				// decrypt multiplies by t0 (the inverse), encrypt by the message
				cmd.op = mrec_pkg::OP_MUL_INIT;
				cmd.sel = (mode_q == mrec_pkg::ModeDecrypt) ? mrec_pkg::SEL_T0 :
					mrec_pkg::SEL_MSG;
				state_d = mrec_pkg::ST_FIN_RUN;
			end
			mrec_pkg::ST_FIN_RUN: begin
				cmd.op = mrec_pkg::OP_MUL_STEP;
				if (sts.cnt_last) state_d = mrec_pkg::ST_FIN_DONE;
			end
			mrec_pkg::ST_FIN_DONE: begin
				cmd.op = mrec_pkg::OP_MUL_DONE;
				state_d = mrec_pkg::ST_FINISH;
			end
			mrec_pkg::ST_FINISH: begin
				// flag only a decrypt secret without inverse, not a small modulus
				cmd.op = mrec_pkg::OP_FINISH;
				cmd.zero_res = bad_q;
				cmd.flag = bad_q && (mode_q == mrec_pkg::ModeDecrypt) &&
					(modulus >= mrec_pkg::WordBits'(2));
				state_d = mrec_pkg::ST_OUT;
			end
			mrec_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = mrec_pkg::ST_IDLE;
			end
			default: state_d = mrec_pkg::ST_IDLE;
		endcase
	end
endmodule

@@ rtl/modexp_rsa_elgamal_cipher_unit.sv @@
// Top level of the modular exponentiation cipher unit (RSA, ElGamal).
// Depends on mrec_pkg, mrec_ctrl and mrec_datapath.
//
// Usage:
//   Configuration: cfg_valid/cfg_ready with cfg_index (0 mode, 1 modulus,
//   2 exponent, 3 public_key) and cfg_data. cfg_ready is always high; write
//   only while the unit is idle. All four indexes are used.
//   Input: in_valid/in_ready with message and ephemeral. One request at a
//   time; in_ready is high only while idle.
//   Output: out_valid/out_ready with result and no_inverse. The result is
//   held until taken; a stalled receiver holds the unit.
//   Sequence: accept and reduce the base, then square for each of the 32
//   exponent bits and multiply for each set bit; finish and present (RSA).
//   Encrypt adds a message reduction and multiply; decrypt adds a divide
//   and multiply per Euclid step (up to about 46 steps), then the same.
//   Modulus below two or mode 3 skips to finish. Rate is set by the single
//   shift-add multiplier and shared divider, one bit per cycle.
//   Reset clears the registers to mode 0, modulus 2, exponent 1,
//   public_key 0 and returns the unit to idle with no output pending.
module modexp_rsa_elgamal_cipher_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [31:0] message,
	input  logic [31:0] ephemeral,
	output logic out_valid,
	input  logic out_ready,
	output logic [31:0] result,
	output logic no_inverse
);
	logic [1:0] mode_q;
	mrec_pkg::word_t modulus_q, exponent_q, public_key_q;
	mrec_pkg::cmd_t cmd;
	mrec_pkg::sts_t sts;
	logic exp_bit, exp_sel_tick;

	assign cfg_ready = 1'b1;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mrec_pkg::ModeRsa;
			modulus_q <= 32'd2;
			exponent_q <= 32'd1;
			public_key_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mrec_pkg::CfgMode:      mode_q <= cfg_data[1:0];
				mrec_pkg::CfgModulus:   modulus_q <= cfg_data;
				mrec_pkg::CfgExponent:  exponent_q <= cfg_data;
				mrec_pkg::CfgPublicKey: public_key_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mrec_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.mode(mode_q), .modulus(modulus_q),
		.sts(sts), .exp_bit(exp_bit), .exp_sel_tick(exp_sel_tick), .cmd(cmd)
	);

	mrec_datapath u_dp (
		.clk(clk), .cmd(cmd),
		.modulus(modulus_q), .exponent(exponent_q), .public_key(public_key_q),
		.mode(mode_q), .message(message), .ephemeral(ephemeral),
		.exp_sel_tick(exp_sel_tick),
		.sts(sts), .exp_bit(exp_bit), .res_word(result), .res_flag(no_inverse)
	);

	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_inverse |-> result == '0) else $error("flag with nonzero result");
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("accept while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result))
		else $error("result dropped under stall");
endmodule
